// ===== rtl/core/lsr_pkg.sv =====
// Shared types and constants for the LIFO stack with reverse.
package lsr_pkg;

	localparam int OP_W     = 3;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH    = 3'd0,
		OP_POP     = 3'd1,
		OP_PEEK    = 3'd2,
		OP_REVERSE = 3'd3,
		OP_QUERY   = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIN,
		S_RV_RD,
		S_RV_WLO,
		S_RV_WHI
	} state_t;

endpackage

// ===== rtl/core/lifo_stack_with_reverse.sv =====
// Top level of the LIFO stack with reverse: sequencer, storage and result register.
//
//  channel | direction | handshake           | beat
//  in      | input     | in_valid / in_stall | operation, push_value
//  out     | output    | out_valid/out_stall | read_value, status, is_empty, element_count
//
// Push, pop, peek, query and unknown codes go from idle to the final state; reverse
// of n elements runs a read state and two write states per swap, floor(n/2) swaps,
// one memory read pair and two writes per swap on the single write port. in_stall
// is high until the result enters the output register; a stalled output holds the
// sequencer in its final state. Reset clears count, state and out_valid, not storage.
module lifo_stack_with_reverse #(
	parameter int ELEM_WIDTH  = 32,
	parameter int STACK_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lsr_pkg::OP_W-1:0]      operation,
	input  logic [lsr_pkg::VAL_W-1:0]     push_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lsr_pkg::VAL_W-1:0]     read_value,
	output logic [lsr_pkg::STATUS_W-1:0]  status,
	output logic                          is_empty,
	output logic [lsr_pkg::COUNT_W-1:0]   element_count
);

	import lsr_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic                  res_valid, res_take;
	logic [VAL_W-1:0]      res_read_value;
	status_t               res_status;
	logic                  res_is_empty;
	logic [COUNT_W-1:0]    res_element_count;
	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_waddr, mem_raddr_a, mem_raddr_b;
	logic [ELEM_WIDTH-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;
	logic                  out_valid_q;
	logic [VAL_W-1:0]      read_value_q;
	status_t               status_q;
	logic                  is_empty_q;
	logic [COUNT_W-1:0]    element_count_q;

	lsr_seq #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.STACK_DEPTH(STACK_DEPTH)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.push_value       (push_value),
		.res_valid        (res_valid),
		.res_take         (res_take),
		.res_read_value   (res_read_value),
		.res_status       (res_status),
		.res_is_empty     (res_is_empty),
		.res_element_count(res_element_count),
		.mem_we           (mem_we),
		.mem_waddr        (mem_waddr),
		.mem_wdata        (mem_wdata),
		.mem_re           (mem_re),
		.mem_raddr_a      (mem_raddr_a),
		.mem_raddr_b      (mem_raddr_b),
		.mem_rdata_a      (mem_rdata_a),
		.mem_rdata_b      (mem_rdata_b)
	);

	lsr_mem #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.STACK_DEPTH(STACK_DEPTH)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr_a(mem_raddr_a),
		.raddr_b(mem_raddr_b),
		.rdata_a(mem_rdata_a),
		.rdata_b(mem_rdata_b)
	);

	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			read_value_q    <= res_read_value;
			status_q        <= res_status;
			is_empty_q      <= res_is_empty;
			element_count_q <= res_element_count;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_value    = read_value_q;
	assign status        = status_q;
	assign is_empty      = is_empty_q;
	assign element_count = element_count_q;

endmodule

// ===== rtl/core/lsr_mem.sv =====
// Stack storage: one write port, two registered read ports.
module lsr_mem #(
	parameter int ELEM_WIDTH  = 32,
	parameter int STACK_DEPTH = 64,
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [ELEM_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr_a,
	input  logic [AW-1:0]         raddr_b,
	output logic [ELEM_WIDTH-1:0] rdata_a,
	output logic [ELEM_WIDTH-1:0] rdata_b
);

	logic [ELEM_WIDTH-1:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/core/lsr_seq.sv =====
// Operation sequencer: stack count, reverse pointers and memory control.
module lsr_seq #(
	parameter int ELEM_WIDTH  = 32,
	parameter int STACK_DEPTH = 64,
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lsr_pkg::OP_W-1:0]      operation,
	input  logic [lsr_pkg::VAL_W-1:0]     push_value,
	output logic                          res_valid,
	input  logic                          res_take,
	output logic [lsr_pkg::VAL_W-1:0]     res_read_value,
	output lsr_pkg::status_t              res_status,
	output logic                          res_is_empty,
	output logic [lsr_pkg::COUNT_W-1:0]   res_element_count,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [ELEM_WIDTH-1:0]         mem_wdata,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_raddr_a,
	output logic [AW-1:0]                 mem_raddr_b,
	input  logic [ELEM_WIDTH-1:0]         mem_rdata_a,
	input  logic [ELEM_WIDTH-1:0]         mem_rdata_b
);

	import lsr_pkg::*;

	state_t          state_q, state_d;
	logic [OP_W-1:0] op_q;
	status_t         status_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   lo_q, hi_q;
	logic            accept, full, empty;
	logic            is_push, is_pop, is_peek, is_rev;
	logic            more_pairs;

	assign accept  = in_valid && (state_q == S_IDLE);
	assign full    = (count_q == CW'(STACK_DEPTH));
	assign empty   = (count_q == '0);
	assign is_push = (operation == OP_PUSH);
	assign is_pop  = (operation == OP_POP);
	assign is_peek = (operation == OP_PEEK);
	assign is_rev  = (operation == OP_REVERSE);
	assign more_pairs = ({1'b0, lo_q} + (AW+1)'(2)) < {1'b0, hi_q};

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mem_we      = 1'b0;
		mem_waddr   = AW'(count_q);
		mem_wdata   = ELEM_WIDTH'(push_value);
		mem_re      = 1'b0;
		mem_raddr_a = AW'(count_q - 1'b1);
		mem_raddr_b = hi_q;
		res_valid   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					mem_we = is_push && !full;
					mem_re = (is_pop || is_peek) && !empty;
					if (is_rev && (count_q >= CW'(2))) begin
						state_d = S_RV_RD;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_RV_RD: begin
				mem_re      = 1'b1;
				mem_raddr_a = lo_q;
				state_d     = S_RV_WLO;
			end
			S_RV_WLO: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q;
				mem_wdata = mem_rdata_b;
				state_d   = S_RV_WHI;
			end
			S_RV_WHI: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = mem_rdata_a;
				state_d   = more_pairs ? S_RV_RD : S_FIN;
			end
			S_FIN: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (is_push && !full) begin
				count_q <= count_q + 1'b1;
			end else if (is_pop && !empty) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			if (is_push && full) begin
				status_q <= STAT_FULL;
			end else if ((is_pop || is_peek) && empty) begin
				status_q <= STAT_EMPTY;
			end else begin
				status_q <= STAT_OK;
			end
			lo_q <= '0;
			hi_q <= AW'(count_q - 1'b1);
		end else if (state_q == S_RV_WHI) begin
			lo_q <= lo_q + 1'b1;
			hi_q <= hi_q - 1'b1;
		end
	end

	always_comb begin
		res_read_value = '0;
		if (((op_q == OP_POP) || (op_q == OP_PEEK)) && (status_q == STAT_OK)) begin
			res_read_value = VAL_W'(mem_rdata_a);
		end
	end

	assign res_status        = status_q;
	assign res_is_empty      = empty;
	assign res_element_count = COUNT_W'(count_q);

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count above depth");

	a_rev_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RV_RD || state_q == S_RV_WLO || state_q == S_RV_WHI)
		|-> (lo_q < hi_q))
		else $error("reverse pointers crossed");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_push && !full) |=> (count_q == CW'($past(count_q) + 1'b1)))
		else $error("push did not advance count");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && status_q == STAT_EMPTY) |-> (count_q == '0))
		else $error("empty status with stored elements");
`endif

endmodule

// ===== tb/sv/lsr_checker.sv =====
// Checker for the LIFO stack with reverse: watches both channels, predicts and compares results.
`timescale 1ns / 100ps

module lsr_checker #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [lsr_pkg::OP_W-1:0]     operation,
	input  logic [lsr_pkg::VAL_W-1:0]    push_value,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [lsr_pkg::VAL_W-1:0]    read_value,
	input  logic [lsr_pkg::STATUS_W-1:0] status,
	input  logic                         is_empty,
	input  logic [lsr_pkg::COUNT_W-1:0]  element_count,
	output int                           mismatches,
	output int                           outstanding
);

	import lsr_pkg::*;

	typedef struct packed {
		logic [VAL_W-1:0]   read_value;
		status_t            status;
		logic               is_empty;
		logic [COUNT_W-1:0] count;
	} stack_result_t;

	logic [VAL_W-1:0] stack_mem [STACK_DEPTH];
	int               depth_used;
	stack_result_t    pending_results [$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
		depth_used  = 0;
	end

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic stack_apply(
		input  logic [OP_W-1:0]  op,
		input  logic [VAL_W-1:0] val,
		output stack_result_t    res
	);
		int               lo;
		int               hi;
		logic [VAL_W-1:0] tmp;
		res.read_value = '0;
		res.status     = STAT_OK;
		case (op) inside
			OP_PUSH: begin
				if (depth_used >= STACK_DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					stack_mem[depth_used] = val;
					depth_used++;
				end
			end
			OP_POP, OP_PEEK: begin
				if (depth_used == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					res.read_value = stack_mem[depth_used-1];
					if (op == OP_POP)
						depth_used--;
				end
			end
			OP_REVERSE: begin
				lo = 0;
				hi = depth_used - 1;
				while (lo < hi) begin
					tmp           = stack_mem[lo];
					stack_mem[lo] = stack_mem[hi];
					stack_mem[hi] = tmp;
					lo++;
					hi--;
				end
			end
			default: begin
			end
		endcase
		res.is_empty = (depth_used == 0);
		res.count    = COUNT_W'(depth_used);
	endtask

	always @(posedge clk) begin
		stack_result_t owed;
		stack_result_t fresh;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report($sformatf("result beat with nothing expected: read_value %h status %0d",
						read_value, status));
				end else begin
					owed = pending_results.pop_front();
					if (read_value !== owed.read_value)
						report($sformatf("read_value got %h, expected %h",
							read_value, owed.read_value));
					if (status !== owed.status)
						report($sformatf("status got %0d, expected %0d", status, owed.status));
					if (is_empty !== owed.is_empty)
						report($sformatf("is_empty got %b, expected %b", is_empty, owed.is_empty));
					if (element_count !== owed.count)
						report($sformatf("element_count got %0d, expected %0d",
							element_count, owed.count));
				end
			end
			if (in_valid && !in_stall) begin
				stack_apply(operation, push_value, fresh);
				pending_results.push_back(fresh);
			end
			outstanding = pending_results.size();
		end
	end

endmodule

// ===== tb/sv/tb_lifo_stack_with_reverse.sv =====
// Top of the LIFO stack with reverse testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module tb_lifo_stack_with_reverse;
	import lsr_pkg::*;

	localparam int STACK_DEPTH = 64;
	localparam int TOTAL_BEATS = 1040;
	localparam int HOLD_AT     = 1000;
	localparam int HOLD_LEN    = 500;
	localparam int DRAIN_WAIT  = 150;
	localparam int CYCLE_LIMIT = 1000000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     operation;
	logic [VAL_W-1:0]    push_value;
	logic                out_valid;
	logic                out_stall;
	logic [VAL_W-1:0]    read_value;
	logic [STATUS_W-1:0] status;
	logic                is_empty;
	logic [COUNT_W-1:0]  element_count;

	int mismatches;
	int outstanding;
	int cycles;
	int beats_sent;
	bit tx_steady;
	bit rx_steady;

	lifo_stack_with_reverse #(
		.ELEM_WIDTH (VAL_W),
		.STACK_DEPTH(STACK_DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_value   (read_value),
		.status       (status),
		.is_empty     (is_empty),
		.element_count(element_count)
	);

	lsr_checker #(
		.STACK_DEPTH(STACK_DEPTH)
	) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_value   (read_value),
		.status       (status),
		.is_empty     (is_empty),
		.element_count(element_count),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [OP_W-1:0] read_op();
		return $urandom_range(0, 1) ? OP_POP : OP_PEEK;
	endfunction

	task automatic send_beat(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
		int gap;
		gap = tx_steady ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		push_value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
		if ($urandom_range(0, 149) == 0)
			tx_steady = !tx_steady;
	endtask

	// receiver: random stalls, one long hold-off to back up the input
	initial begin
		int  rx_cycles;
		int  run_left;
		bit  stalling;
		rx_cycles = 0;
		run_left  = 0;
		stalling  = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			rx_cycles++;
			if ($urandom_range(0, 199) == 0)
				rx_steady = !rx_steady;
			if (rx_cycles == HOLD_AT) begin
				stalling = 1'b1;
				run_left = HOLD_LEN;
			end else if (run_left == 0) begin
				if (stalling) begin
					stalling = 1'b0;
					run_left = rx_steady ? $urandom_range(20, 80) : $urandom_range(1, 6);
				end else begin
					run_left = idle_len();
					stalling = (run_left != 0) && !rx_steady;
				end
			end else begin
				run_left--;
			end
			out_stall <= stalling;
		end
	end

	initial begin
		int kind;
		int len;
		cycles      = 0;
		beats_sent  = 0;
		tx_steady   = 1'b0;
		rx_steady   = 1'b0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		operation  <= OP_QUERY;
		push_value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty stack, single element, value extremes, unknown codes
		send_beat(OP_POP, '1);
		send_beat(OP_PEEK, '0);
		send_beat(OP_QUERY, '0);
		send_beat(OP_REVERSE, '0);
		send_beat(OP_PUSH, '0);
		send_beat(OP_REVERSE, '1);
		send_beat(OP_PEEK, '0);
		send_beat(OP_QUERY, '1);
		send_beat(OP_PUSH, '1);
		send_beat(OP_PUSH, 32'h5555_5555);
		send_beat(OP_PUSH, 32'hAAAA_AAAA);
		send_beat(OP_REVERSE, '0);
		send_beat(OP_PEEK, '0);
		send_beat(OP_POP, '0);
		for (int k = OP_QUERY + 1; k < (1 << OP_W); k++)
			send_beat(k[OP_W-1:0], '1);
		send_beat(OP_POP, '0);
		send_beat(OP_POP, '0);
		send_beat(OP_POP, '0);
		send_beat(OP_QUERY, '0);

		while (beats_sent < TOTAL_BEATS) begin
			kind = $urandom_range(0, 19);
			case (kind) inside
				[0:4]: begin
					len = $urandom_range(1, 12);
					repeat (len) send_beat(OP_PUSH, $urandom);
				end
				5: begin
					len = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 8);
					repeat (len) send_beat(OP_PUSH, $urandom);
				end
				[6:10]: begin
					len = $urandom_range(1, 12);
					repeat (len) send_beat(read_op(), $urandom);
				end
				11: begin
					len = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 8);
					repeat (len) send_beat(OP_POP, $urandom);
				end
				[12:13]: begin
					send_beat(OP_REVERSE, $urandom);
					len = $urandom_range(1, 4);
					repeat (len) send_beat(read_op(), $urandom);
				end
				[14:17]: begin
					len = $urandom_range(1, 10);
					repeat (len)
						send_beat(OP_W'($urandom_range(OP_PUSH, OP_QUERY)), $urandom);
				end
				default: begin
					len = $urandom_range(1, 4);
					repeat (len)
						send_beat(OP_W'($urandom_range(0, (1 << OP_W) - 1)), $urandom);
				end
			endcase
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
